FILE: design/assert_macros.svh
// Assertion macros for the port-level checker of the moving average block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWA_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("moving average check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RWA_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("moving average check failed");

`endif

FILE: design/rwa_pkg.sv
// Package with the shared widths and defaults of the moving average block.
package rwa_pkg;

    // Width of one signed sample and of one signed average.
    localparam int RWA_SAMPLE_W = 16;

    // Width of the window length register as seen on the configuration port.
    localparam int RWA_WIN_W = 5;

    // Window length after reset, before clamping to the store depth.
    localparam int RWA_WIN_RESET = 16;

    // Default depth of the sample store.
    localparam int RWA_MAX_SAMPLES = 16;

endpackage

FILE: design/rwa_serial_div.sv
// Bit-serial restoring divider that turns the window sum into the average.
module rwa_serial_div #(
    parameter int SUM_W = 21,
    parameter int CNT_W = 5
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic                                  ack,
    input  logic [SUM_W-1:0]                      dividend,
    input  logic                                  negate,
    input  logic [CNT_W-1:0]                      divisor,
    output logic                                  done,
    output logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] quotient
);
    import rwa_pkg::*;

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

    div_state_t              state_reg;
    div_state_t              state_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [SUM_W-1:0]        shift_reg;
    logic [SUM_W-1:0]        shift_next;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        rem_next;
    logic [CNT_W-1:0]        divisor_reg;
    logic                    neg_reg;
    logic [CNT_W:0]          trial;
    logic [CNT_W:0]          diff;
    logic                    fits;
    logic [RWA_SAMPLE_W-1:0] qmag;

    // One quotient bit per cycle: the dividend leaves at the top of the
    // shift register while the quotient bits enter at the bottom.
    assign trial = {rem_reg, shift_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_RUN;
                    step_next  = '0;
                    shift_next = dividend;
                    rem_next   = '0;
                end
            end
            DIV_RUN:
            begin
                shift_next = {shift_reg[SUM_W-2:0], fits};
                rem_next   = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = DIV_HOLD;
                end
            end
            DIV_HOLD:
            begin
                if (ack)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        if (state_reg == DIV_IDLE && start)
        begin
            divisor_reg <= divisor;
            neg_reg     <= negate;
        end
    end

    // The magnitude of a mean of 16-bit samples fits in 16 bits, 32768 included.
    assign qmag     = shift_reg[RWA_SAMPLE_W-1:0];
    assign quotient = neg_reg ? $signed(-qmag) : $signed(qmag);
    assign done     = (state_reg == DIV_HOLD);

endmodule

FILE: design/running_window_average_core.sv
// Top level of the moving average block: sample store, running sum and control.
//
// Usage. Samples enter on the sample channel (sample, sample_valid,
// sample_stall); a request is taken at a rising edge where sample_valid is
// high and sample_stall is low. Each request yields exactly one average on
// the average channel (average, average_valid, average_stall), taken at an
// edge where average_valid is high and average_stall is low.
// The window length is written through its own channel (window_length,
// window_length_valid, window_length_ready). A write clamps the value to
// the range 1 to MAX_SAMPLES and clears the sum, the write index and the
// fill count. Writes are taken only while no request is in flight.
// Sequence. A request passes through the states READ, UPDATE, START and
// DIVIDE; its average is registered once the output register is free.
// The bit-serial divider yields one quotient bit per cycle over the SUM_W
// bits of the running sum. One request at a time. The average sits in an
// output register, so the next sample is accepted as soon as a result has
// moved there, even while the receiver stalls; a stalled receiver only
// holds back the following result.
// Reset. Reset sets the window to 16 (clamped to MAX_SAMPLES) and clears the
// sum and counters; the store needs no clearing, since an entry is read
// only after the current window has written it.
module running_window_average_core #(
    parameter int MAX_SAMPLES = rwa_pkg::RWA_MAX_SAMPLES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] sample,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    output logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] average,
    output logic                                  average_valid,
    input  logic                                  average_stall,
    input  logic [rwa_pkg::RWA_WIN_W-1:0]           window_length,
    input  logic                                  window_length_valid,
    output logic                                  window_length_ready
);
    import rwa_pkg::*;

    // Count and window need to hold MAX_SAMPLES itself; the index does not.
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SUM_W = RWA_SAMPLE_W + CNT_W;
    localparam int WIN_RESET = (RWA_WIN_RESET > MAX_SAMPLES) ? MAX_SAMPLES : RWA_WIN_RESET;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_W-1:0]           window_reg;
    logic [CNT_W-1:0]           window_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;
    logic                       full_reg;
    logic                       full_next;
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic                       avg_valid_reg;
    logic                       avg_valid_next;

    logic signed [RWA_SAMPLE_W-1:0] sample_reg;
    logic signed [RWA_SAMPLE_W-1:0] old_reg;
    logic signed [RWA_SAMPLE_W-1:0] avg_reg;
    logic signed [RWA_SAMPLE_W-1:0] store_mem [MAX_SAMPLES];

    logic                       sample_take;
    logic                       cfg_take;
    logic                       out_free;
    logic [CNT_W-1:0]           win_clamped;
    logic [CNT_W:0]             idx_plus;
    logic signed [SUM_W-1:0]    sample_ext;
    logic signed [SUM_W-1:0]    old_ext;
    logic [SUM_W-1:0]           sum_mag;
    logic                       div_start;
    logic                       div_ack;
    logic                       div_done;
    logic signed [RWA_SAMPLE_W-1:0] div_quot;

    // Handshakes. A configuration write shuts the sample channel for that
    // cycle so the two never land on the same edge.
    assign window_length_ready = (state_reg == ST_IDLE);
    assign sample_stall        = (state_reg != ST_IDLE) || window_length_valid;
    assign sample_take         = sample_valid && !sample_stall;
    assign cfg_take            = window_length_valid && window_length_ready;
    assign out_free            = !avg_valid_reg || !average_stall;

    // A window of zero means one sample; anything past the store depth is
    // cut back to the depth.
    always_comb
    begin
        if (window_length == '0)
        begin
            win_clamped = CNT_W'(1);
        end
        else if (int'(window_length) > MAX_SAMPLES)
        begin
            win_clamped = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            win_clamped = CNT_W'(window_length);
        end
    end

    // The incremented index is one bit wider than the count, so the wrap
    // test also works when the window fills the whole store.
    assign idx_plus   = (CNT_W + 1)'(idx_reg) + (CNT_W + 1)'(1);
    assign sample_ext = SUM_W'(sample_reg);
    assign old_ext    = SUM_W'(old_reg);
    assign sum_mag    = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_comb
    begin
        state_next     = state_reg;
        window_next    = window_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        full_next      = full_reg;
        sum_next       = sum_reg;
        avg_valid_next = avg_valid_reg && average_stall;
        div_start      = 1'b0;
        div_ack        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_take)
                begin
                    window_next = win_clamped;
                    count_next  = '0;
                    idx_next    = '0;
                    sum_next    = '0;
                end
                else if (sample_take)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // The store is read and written at the same index here; the
                // read returns the sample that is about to leave the window.
                full_next = (count_reg == window_reg);
                if (count_reg != window_reg)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                if (idx_plus == {1'b0, window_reg})
                begin
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_plus[IDX_W-1:0];
                end
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (full_reg)
                begin
                    sum_next = sum_reg + sample_ext - old_ext;
                end
                else
                begin
                    sum_next = sum_reg + sample_ext;
                end
                state_next = ST_START;
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done && out_free)
                begin
                    div_ack        = 1'b1;
                    avg_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= CNT_W'(WIN_RESET);
            count_reg     <= '0;
            idx_reg       <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            full_reg      <= full_next;
            sum_reg       <= sum_next;
            avg_valid_reg <= avg_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            sample_reg <= sample;
        end
        if (div_ack)
        begin
            avg_reg <= div_quot;
        end
    end

    // Sample store: one port, read before write at the current index.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            old_reg            <= store_mem[idx_reg];
            store_mem[idx_reg] <= sample_reg;
        end
    end

    // The divider sees the magnitude of the sum and the fill count, which is
    // at least one after any sample.
    rwa_serial_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ack      (div_ack),
        .dividend (sum_mag),
        .negate   (sum_reg[SUM_W-1]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign average       = avg_reg;
    assign average_valid = avg_valid_reg;

endmodule

FILE: design/rwa_checker.sv
// Port-level checker for the moving average block, bound to its top level.
`include "assert_macros.svh"

module rwa_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  sample_valid,
    input logic                                  sample_stall,
    input logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] average,
    input logic                                  average_valid,
    input logic                                  average_stall,
    input logic                                  window_length_valid,
    input logic                                  window_length_ready
);

    // A stalled average stays valid and unchanged.
    `RWA_ASSERT_NXT(a_avg_hold, clk, rst_n, average_valid && average_stall, average_valid && $stable(average))

    // After a sample is taken the block is busy: no sample, no register write.
    `RWA_ASSERT_NXT(a_busy_after_take, clk, rst_n, sample_valid && !sample_stall, sample_stall && !window_length_ready)

    // A new average only shows up once the block has been busy.
    `RWA_ASSERT_IMP(a_avg_after_work, clk, rst_n, $rose(average_valid), $past(sample_stall))

    // While idle, samples are held off exactly when a register write is offered.
    `RWA_ASSERT_IMP(a_cfg_excludes_sample, clk, rst_n, window_length_ready, sample_stall == window_length_valid)

endmodule

bind running_window_average_core rwa_checker u_rwa_checker (.*);

FILE: bench/average_checker.sv
// Checker that predicts every moving average and compares it with the block's output.
`timescale 1ns / 100ps

module average_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] sample,
    input  logic                                   sample_valid,
    input  logic                                   sample_stall,
    input  logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] average,
    input  logic                                   average_valid,
    input  logic                                   average_stall,
    input  logic [rwa_pkg::RWA_WIN_W-1:0]           window_length,
    input  logic                                   window_length_valid,
    input  logic                                   window_length_ready,
    output int                                     mismatches,
    output int                                     pending,
    output int                                     averages_seen
);

    localparam int DEPTH = rwa_pkg::RWA_MAX_SAMPLES;

    // Shadow copy of the block's window state.
    logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] held_samples [DEPTH];
    logic signed [20:0]                      running_total;
    logic [3:0]                              write_slot;
    logic [4:0]                              fill;
    logic [4:0]                              window_len;

    logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] expected_averages [$];
    int                                      err_count;
    int                                      seen_count;

    // A zero is taken as one and anything above the store depth is cut back to it.
    function automatic logic [4:0] clamp_window(input logic [4:0] value);
        if (value == 5'd0)
            return 5'd1;
        if (int'(value) > DEPTH)
            return 5'(DEPTH);
        return value;
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < DEPTH; i++)
            held_samples[i] = '0;
        running_total = '0;
        write_slot    = '0;
        fill          = '0;
    endfunction

    // Advances the window by one sample and returns the truncated mean.
    function automatic logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] next_average(
        input logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] value
    );
        int slot;
        int quotient;
        slot = int'(write_slot);
        if (slot >= int'(window_len))
            slot = 0;
        if (fill < window_len)
            fill = fill + 5'd1;
        else
            running_total = running_total - held_samples[slot];
        held_samples[slot] = value;
        running_total      = running_total + value;
        slot++;
        if (slot >= int'(window_len))
            slot = 0;
        write_slot = 4'(slot);
        // SystemVerilog integer division truncates toward zero.
        quotient = int'(running_total) / int'(fill);
        return quotient[rwa_pkg::RWA_SAMPLE_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] wanted;
        if (!rst_n)
        begin
            window_len = clamp_window(5'(rwa_pkg::RWA_WIN_RESET));
            clear_window();
            expected_averages.delete();
            err_count     = 0;
            seen_count    = 0;
            mismatches    <= 0;
            pending       <= 0;
            averages_seen <= 0;
        end
        else
        begin
            if (window_length_valid && window_length_ready)
            begin
                window_len = clamp_window(window_length);
                clear_window();
            end
            if (sample_valid && !sample_stall)
                expected_averages.push_back(next_average(sample));
            if (average_valid && !average_stall)
            begin
                seen_count++;
                if (expected_averages.size() == 0)
                begin
                    err_count++;
                    $error("average arrived with no request outstanding: actual %0d", average);
                end
                else
                begin
                    wanted = expected_averages.pop_front();
                    if (average !== wanted)
                    begin
                        err_count++;
                        $error("average mismatch: expected %0d, actual %0d", wanted, average);
                    end
                end
            end
            mismatches    <= err_count;
            pending       <= expected_averages.size();
            averages_seen <= seen_count;
        end
    end

endmodule

FILE: bench/tb.sv
// Testbench top: drives samples and window writes into the moving average block.
`timescale 1ns / 100ps

module tb;

    // No request may sit unaccepted on every channel for this many cycles. A
    // correct run never comes near it, even with the longest sender gaps and
    // receiver stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int TAIL_ITEMS     = 150;
    localparam int DRAIN_CYCLES   = 40;

    logic                                   clk = 1'b0;
    logic                                   rst_n;
    logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] sample;
    logic                                   sample_valid;
    logic                                   sample_stall;
    logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] average;
    logic                                   average_valid;
    logic                                   average_stall = 1'b0;
    logic [rwa_pkg::RWA_WIN_W-1:0]           window_length;
    logic                                   window_length_valid;
    logic                                   window_length_ready;

    int mismatches;
    int pending;
    int averages_seen;

    // Idling controls. The sender flag is read only by the stimulus process,
    // so it is set there directly; the receiver flag feeds the stall process.
    bit sender_idles;
    bit receiver_stalls = 1'b0;
    int stall_left      = 0;
    int idle_cycles     = 0;
    int items_sent      = 0;
    int writes_done     = 0;

    always #5 clk = ~clk;

    running_window_average_core dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .sample              (sample),
        .sample_valid        (sample_valid),
        .sample_stall        (sample_stall),
        .average             (average),
        .average_valid       (average_valid),
        .average_stall       (average_stall),
        .window_length       (window_length),
        .window_length_valid (window_length_valid),
        .window_length_ready (window_length_ready)
    );

    // The checker sits beside the block and sees exactly what crosses its ports.
    average_checker avg_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .sample              (sample),
        .sample_valid        (sample_valid),
        .sample_stall        (sample_stall),
        .average             (average),
        .average_valid       (average_valid),
        .average_stall       (average_stall),
        .window_length       (window_length),
        .window_length_valid (window_length_valid),
        .window_length_ready (window_length_ready),
        .mismatches          (mismatches),
        .pending             (pending),
        .averages_seen       (averages_seen)
    );

    // The receiver stalls in bursts of random length. A burst starts when the
    // random draw hits and then holds while stall_left counts down.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            average_stall <= 1'b1;
            stall_left    <= stall_left - 1;
        end
        else if (receiver_stalls && $urandom_range(3) == 0)
        begin
            average_stall <= 1'b1;
            stall_left    <= $urandom_range(4);
        end
        else
        begin
            average_stall <= 1'b0;
        end
    end

    // The watchdog counts cycles in which no channel moves anything.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (average_valid && !average_stall) ||
            (window_length_valid && window_length_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles.", idle_cycles);
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Samples are mostly full-range noise, with a share of small values near
    // zero (where truncation toward zero matters most) and the extremes.
    function automatic logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
        begin
            case ($urandom_range(3))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                default: return 16'shffff;
            endcase
        end
        if (pick <= 2)
            return 16'(int'($urandom_range(200)) - 100);
        return 16'($urandom);
    endfunction

    // Waits until every request has produced its average. The first edge lets
    // the checker's count catch up with a request taken at the current edge.
    task automatic wait_drained();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Presents one sample, optionally after an idle gap, and returns at the
    // edge where it is taken. Valid stays high so that a following sample
    // can go out back to back; the caller lowers it at the end of a phase.
    task automatic send_sample(input logic signed [rwa_pkg::RWA_SAMPLE_W-1:0] value);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= value;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Window writes are only issued once the block has delivered every average.
    task automatic write_window(input logic [rwa_pkg::RWA_WIN_W-1:0] value);
        wait_drained();
        window_length       <= value;
        window_length_valid <= 1'b1;
        @(posedge clk);
        while (!window_length_ready)
            @(posedge clk);
        window_length_valid <= 1'b0;
        writes_done++;
    endtask

    initial
    begin
        int opening_windows [8];
        int random_count;
        int phase;
        int length;

        opening_windows = '{1, 17, 16, 2, 0, 31, 8, 15};

        rst_n               <= 1'b0;
        sample              <= '0;
        sample_valid        <= 1'b0;
        window_length       <= '0;
        window_length_valid <= 1'b0;
        sender_idles        = 1'b1;
        receiver_stalls     <= 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The reset window of 16 first sees the edge values
        // while it is still filling.
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shffff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        sample_valid <= 1'b0;

        // A written zero acts as a window of one: each average is the sample.
        write_window(5'd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'shffff);
        sample_valid <= 1'b0;

        // All ones is clamped to the store depth. Sixteen most-negative
        // samples drive the sum to its lowest value, and one more request
        // evicts the oldest sample from a full window.
        write_window(5'd31);
        repeat (16) send_sample(16'sh8000);
        send_sample(16'sh7fff);
        sample_valid <= 1'b0;

        // Random phases, each under a new window setting. The first settings
        // cover the clamping cases; later ones are drawn from the full field.
        random_count = 0;
        phase        = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (phase < 8)
                write_window(5'(opening_windows[phase]));
            else
                write_window(5'($urandom_range(31)));
            // The sender and the receiver each run without idling in roughly one phase in four.
            sender_idles    = ($urandom_range(3) != 0);
            receiver_stalls <= ($urandom_range(3) != 0);
            length = $urandom_range(20, 100);
            for (int i = 0; i < length; i++)
                send_sample(random_sample());
            sample_valid <= 1'b0;
            random_count += length;
            phase++;
        end

        // Final stretch at full rate on both sides.
        write_window(5'($urandom_range(31)));
        sender_idles    = 1'b0;
        receiver_stalls <= 1'b0;
        for (int i = 0; i < TAIL_ITEMS; i++)
            send_sample(random_sample());
        sample_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples under %0d window writes plus the reset window.",
                 items_sent, writes_done);
        $display("Compared %0d averages; %0d mismatches, %0d still outstanding.",
                 averages_seen, mismatches, pending);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/rwa_pkg.sv
design/rwa_serial_div.sv
design/running_window_average_core.sv
design/rwa_checker.sv
bench/average_checker.sv
bench/tb.sv
